// ===== hw/rtl/tlbc_pkg.sv =====
// Shared types, codes and helper functions of the two-tier byte-budget LRU cache.
package tlbc_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int KEY_W       = 24;
	localparam int LEN_W       = 40;
	localparam int TOT_W       = 48;
	localparam int CNT_OUT_W   = 7;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FAST_BUDGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_BUDGET = 2'd1;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [1:0] CLR_FAST  = 2'd0;
	localparam logic [1:0] CLR_SLOW  = 2'd1;
	localparam logic [1:0] CLR_BOTH  = 2'd2;
	localparam logic [1:0] CLR_ORDER = 2'd3;

	localparam logic [2:0] OUT_FAST_HIT    = 3'd0;
	localparam logic [2:0] OUT_SLOW_HIT    = 3'd1;
	localparam logic [2:0] OUT_FILLED_FAST = 3'd2;
	localparam logic [2:0] OUT_FILLED_SLOW = 3'd3;
	localparam logic [2:0] OUT_UNCACHED    = 3'd4;
	localparam logic [2:0] OUT_CLEARED     = 3'd5;

	localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

	typedef struct packed {
		logic             req_type;
		logic [7:0]       owner_handle;
		logic [15:0]      item_index;
		logic [LEN_W-1:0] want_bytes;
		logic [LEN_W-1:0] stored_bytes;
		logic [1:0]       clear_level;
	} req_t;

	typedef struct packed {
		logic [2:0]           outcome;
		logic [CNT_OUT_W-1:0] evicted_count;
		logic [TOT_W-1:0]     fast_used;
		logic [TOT_W-1:0]     slow_used;
		logic [CNT_OUT_W-1:0] fast_items;
		logic [CNT_OUT_W-1:0] slow_items;
	} rsp_t;

	// One slot's contents (recency rank travels beside it, its width follows ENTRIES).
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             fp;
		logic [LEN_W-1:0] fl;
		logic             sp;
		logic [LEN_W-1:0] sl;
		logic             ord;
		logic             sel;
	} entry_t;

	// Broadcast command to every cell.
	typedef struct packed {
		logic shift;
		logic touch;
		logic clear;
		logic clr_fast;
		logic clr_slow;
		logic pivot_ord;
	} cell_cmd_t;

	function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [31:0] v);
		return (v > 32'd127) ? 7'd127 : v[CNT_OUT_W-1:0];
	endfunction

	function automatic logic [TOT_W-1:0] add_sat(input logic [TOT_W-1:0] a,
			input logic [LEN_W-1:0] b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {{(TOT_W-LEN_W+1){1'b0}}, b};
		return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
	endfunction

	function automatic logic [TOT_W-1:0] sub_floor(input logic [TOT_W-1:0] a,
			input logic [LEN_W-1:0] b);
		logic [TOT_W-1:0] bx;
		bx = {{(TOT_W-LEN_W){1'b0}}, b};
		return (a > bx) ? (a - bx) : '0;
	endfunction

endpackage

// ===== hw/rtl/tlbc_cell.sv =====
// One slot of the rotating entry ring: holds a key, both tier copies and a recency rank.
module tlbc_cell import tlbc_pkg::*; #(
	parameter int RANK_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [RANK_W-1:0] pivot_rank,
	input  entry_t            nxt_ent,
	input  logic [RANK_W-1:0] nxt_rank,
	output entry_t            ent,
	output logic [RANK_W-1:0] rank
);

	logic             fp_q, sp_q, ord_q, sel_q;
	logic [RANK_W-1:0] rank_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] fl_q, sl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q   <= 1'b0;
			sp_q   <= 1'b0;
			ord_q  <= 1'b0;
			sel_q  <= 1'b0;
			rank_q <= '0;
		end else if (cmd.shift) begin
			fp_q   <= nxt_ent.fp;
			sp_q   <= nxt_ent.sp;
			ord_q  <= nxt_ent.ord;
			sel_q  <= nxt_ent.sel;
			rank_q <= nxt_rank;
		end else if (cmd.touch) begin
			if (sel_q) begin
				ord_q  <= 1'b1;
				rank_q <= '0;
				sel_q  <= 1'b0;
			end else if (ord_q && (!cmd.pivot_ord || rank_q < pivot_rank)) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end else if (cmd.clear) begin
			if (cmd.clr_fast) fp_q <= 1'b0;
			if (cmd.clr_slow) sp_q <= 1'b0;
			ord_q  <= 1'b0;
			rank_q <= '0;
		end
	end

	// key and lengths are only meaningful while the matching flag is set
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			key_q <= nxt_ent.key;
			fl_q  <= nxt_ent.fl;
			sl_q  <= nxt_ent.sl;
		end
	end

	always_comb begin
		ent.key = key_q;
		ent.fp  = fp_q;
		ent.fl  = fl_q;
		ent.sp  = sp_q;
		ent.sl  = sl_q;
		ent.ord = ord_q;
		ent.sel = sel_q;
		rank    = rank_q;
	end

endmodule

// ===== hw/rtl/two_tier_lru_byte_budget_cache_top.sv =====
// Two-tier LRU cache bookkeeping with per-tier byte budgets: cell ring and sequencer.
// Flow: a clear and an immediate miss (zero length or invalid key) go straight to S_FINISH.
// A read walks the ring once in S_LOOKUP and on a hit goes on through S_TOUCH to S_FINISH; a fill
// adds tier checks and a slot walk, and one more ring seek for each evicted entry.
// Throughput: one transaction at a time; start is taken only while busy is low; no stalls.
// Reset: async active low, empties both tiers and the recency order, zeroes budgets.
module two_tier_lru_byte_budget_cache_top import tlbc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [LEN_W-1:0]     cfg_wdata
);

	localparam int RW = $clog2(ENTRIES);      // recency rank
	localparam int OW = $clog2(ENTRIES + 1);  // counts up to ENTRIES
	localparam int CW = $clog2(ENTRIES);      // ring walk position

	typedef enum logic [3:0] {
		S_IDLE, S_LOOKUP, S_DECIDE, S_SLOW_TRY, S_EV_CHK, S_EV_SEEK,
		S_FILL_SEEK, S_FILL_ADD, S_TOUCH, S_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [LEN_W-1:0] fb_q, sb_q;

	// transaction context
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic             tier_q;        // 0 fast, 1 slow
	logic [2:0]       out_q;
	logic [CNT_OUT_W-1:0] ev_q;
	logic [CW-1:0]    cnt_q;
	logic [OW-1:0]    free_q;
	logic             found_q, sel_live_q;
	logic             hit_fp_q, hit_sp_q, hit_ord_q;
	logic [LEN_W-1:0] hit_fl_q, hit_sl_q;
	logic [RW-1:0]    hit_rank_q;
	logic             pord_q;
	logic [RW-1:0]    prank_q;

	// global bookkeeping
	logic [TOT_W-1:0] ft_q, st_q;
	logic [OW-1:0]    fi_q, si_q, ocnt_q;

	logic done_q;
	rsp_t rsp_q;

	// ring of cells: cell 0 is the head seen by the sequencer
	entry_t        ent_a  [ENTRIES];
	logic [RW-1:0] rank_a [ENTRIES];
	entry_t        head_mod;
	logic [RW-1:0] head_rank_mod;
	cell_cmd_t     cmd;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			if (g == ENTRIES - 1) begin : g_tail
				tlbc_cell #(.RANK_W(RW)) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .pivot_rank(prank_q),
					.nxt_ent(head_mod), .nxt_rank(head_rank_mod),
					.ent(ent_a[g]), .rank(rank_a[g])
				);
			end else begin : g_mid
				tlbc_cell #(.RANK_W(RW)) u_cell (
					.clk(clk), .arst_n(arst_n), .cmd(cmd), .pivot_rank(prank_q),
					.nxt_ent(ent_a[g+1]), .nxt_rank(rank_a[g+1]),
					.ent(ent_a[g]), .rank(rank_a[g])
				);
			end
		end
	endgenerate

	entry_t        head;
	logic [RW-1:0] head_rank;
	logic          in_use_h, lk_match, victim, fill_tgt, start_acc;
	logic          is_clear, clr_f, clr_s;
	logic [LEN_W-1:0] rd_len;
	logic [TOT_W:0]   tot_need;
	logic [TOT_W-1:0] tier_tot;
	logic [LEN_W-1:0] tier_bud;
	logic             over;
	logic             st_over;

	assign head      = ent_a[0];
	assign head_rank = rank_a[0];
	assign in_use_h  = head.fp || head.sp || head.ord;
	assign lk_match  = in_use_h && (head.key == key_q);
	assign victim    = head.ord && (head_rank == RW'(ocnt_q - OW'(1)));
	// fill goes to the key's own slot if it still lives, else to any free slot
	assign fill_tgt  = sel_live_q ? head.sel : !in_use_h;
	assign start_acc = start && (state_q == S_IDLE);
	assign is_clear  = req.req_type == REQ_CLEAR;
	assign clr_f     = (req.clear_level == CLR_FAST) || (req.clear_level == CLR_BOTH);
	assign clr_s     = (req.clear_level == CLR_SLOW) || (req.clear_level == CLR_BOTH);
	assign rd_len    = (req.want_bytes < req.stored_bytes) ? req.want_bytes
	                                                       : req.stored_bytes;
	assign tier_tot  = tier_q ? st_q : ft_q;
	assign tier_bud  = tier_q ? sb_q : fb_q;
	assign tot_need  = {1'b0, tier_tot} + {{(TOT_W-LEN_W+1){1'b0}}, len_q};
	assign over      = tot_need > {{(TOT_W-LEN_W+1){1'b0}}, tier_bud};
	// fast eviction drops the slow copy too while the slow tier is over budget
	assign st_over   = st_q > {{(TOT_W-LEN_W){1'b0}}, sb_q};

	always_comb begin
		head_mod      = head;
		head_rank_mod = head_rank;
		cmd           = '0;
		cmd.pivot_ord = pord_q;
		cmd.shift     = (state_q == S_LOOKUP) || (state_q == S_EV_SEEK)
		             || (state_q == S_FILL_SEEK);
		cmd.touch     = state_q == S_TOUCH;
		cmd.clear     = start_acc && is_clear;
		cmd.clr_fast  = clr_f;
		cmd.clr_slow  = clr_s;
		case (state_q)
			S_LOOKUP: begin
				head_mod.sel = lk_match;
			end
			S_EV_SEEK: begin
				if (victim) begin
					if (!tier_q) begin
						head_mod.fp = 1'b0;
						if (st_over) head_mod.sp = 1'b0;
					end else begin
						head_mod.sp = 1'b0;
					end
					head_mod.ord  = 1'b0;
					head_rank_mod = '0;
					if (!head_mod.fp && !head_mod.sp) head_mod.sel = 1'b0;
				end
			end
			S_FILL_SEEK: begin
				if (fill_tgt) begin
					head_mod.key = key_q;
					head_mod.sel = 1'b1;
					if (!tier_q) begin
						head_mod.fp = 1'b1;
						head_mod.fl = len_q;
					end else begin
						head_mod.sp = 1'b1;
						head_mod.sl = len_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fb_q       <= '0;
			sb_q       <= '0;
			key_q      <= '0;
			len_q      <= '0;
			tier_q     <= 1'b0;
			out_q      <= OUT_UNCACHED;
			ev_q       <= '0;
			cnt_q      <= '0;
			free_q     <= '0;
			found_q    <= 1'b0;
			sel_live_q <= 1'b0;
			hit_fp_q   <= 1'b0;
			hit_sp_q   <= 1'b0;
			hit_ord_q  <= 1'b0;
			hit_fl_q   <= '0;
			hit_sl_q   <= '0;
			hit_rank_q <= '0;
			pord_q     <= 1'b0;
			prank_q    <= '0;
			ft_q       <= '0;
			st_q       <= '0;
			fi_q       <= '0;
			si_q       <= '0;
			ocnt_q     <= '0;
			done_q     <= 1'b0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_FAST_BUDGET) fb_q <= cfg_wdata;
				if (cfg_idx == REG_SLOW_BUDGET) sb_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						ev_q <= '0;
						if (is_clear) begin
							ev_q   <= sat_cnt(32'(ocnt_q));
							ocnt_q <= '0;
							if (clr_f) begin
								ft_q <= '0;
								fi_q <= '0;
							end
							if (clr_s) begin
								st_q <= '0;
								si_q <= '0;
							end
							out_q   <= OUT_CLEARED;
							state_q <= S_FINISH;
						end else if (rd_len == '0) begin
							// invalid key or zero length: nothing to look up
							out_q   <= OUT_UNCACHED;
							state_q <= S_FINISH;
						end else begin
							key_q      <= {req.owner_handle, req.item_index};
							len_q      <= rd_len;
							found_q    <= 1'b0;
							sel_live_q <= 1'b0;
							free_q     <= '0;
							cnt_q      <= '0;
							state_q    <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					if (lk_match) begin
						found_q    <= 1'b1;
						sel_live_q <= 1'b1;
						hit_fp_q   <= head.fp;
						hit_fl_q   <= head.fl;
						hit_sp_q   <= head.sp;
						hit_sl_q   <= head.sl;
						hit_ord_q  <= head.ord;
						hit_rank_q <= head_rank;
					end
					if (!in_use_h) free_q <= free_q + OW'(1);
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(ENTRIES - 1)) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					pord_q  <= hit_ord_q;
					prank_q <= hit_rank_q;
					if (found_q && hit_fp_q && hit_fl_q == len_q) begin
						out_q   <= OUT_FAST_HIT;
						state_q <= S_TOUCH;
					end else if (found_q && hit_sp_q && hit_sl_q == len_q) begin
						out_q   <= OUT_SLOW_HIT;
						state_q <= S_TOUCH;
					end else if (fb_q >= len_q) begin
						tier_q  <= 1'b0;
						state_q <= S_EV_CHK;
					end else begin
						state_q <= S_SLOW_TRY;
					end
				end
				S_SLOW_TRY: begin
					if (sb_q >= len_q) begin
						tier_q  <= 1'b1;
						state_q <= S_EV_CHK;
					end else begin
						out_q   <= OUT_UNCACHED;
						state_q <= S_FINISH;
					end
				end
				S_EV_CHK: begin
					if (over && ocnt_q != '0) begin
						state_q <= S_EV_SEEK;
					end else if (!over && (sel_live_q || free_q != '0)) begin
						state_q <= S_FILL_SEEK;
					end else if (!tier_q) begin
						// fast tier could not take it: try the slow tier
						state_q <= S_SLOW_TRY;
					end else begin
						out_q   <= OUT_UNCACHED;
						state_q <= S_FINISH;
					end
				end
				S_EV_SEEK: begin
					if (victim) begin
						if (!tier_q) begin
							if (head.fp) begin
								ft_q <= sub_floor(ft_q, head.fl);
								fi_q <= fi_q - OW'(1);
							end
							if (head.sp && st_over) begin
								st_q <= sub_floor(st_q, head.sl);
								si_q <= si_q - OW'(1);
							end
						end else if (head.sp) begin
							st_q <= sub_floor(st_q, head.sl);
							si_q <= si_q - OW'(1);
						end
						ocnt_q <= ocnt_q - OW'(1);
						if (ev_q != 7'd127) ev_q <= ev_q + 7'd1;
						if (!head_mod.fp && !head_mod.sp) begin
							free_q <= free_q + OW'(1);
							if (head.sel) sel_live_q <= 1'b0;
						end
						state_q <= S_EV_CHK;
					end
				end
				S_FILL_SEEK: begin
					if (fill_tgt) begin
						if (!tier_q) begin
							if (head.fp) ft_q <= sub_floor(ft_q, head.fl);
							else         fi_q <= fi_q + OW'(1);
							out_q <= OUT_FILLED_FAST;
						end else begin
							if (head.sp) st_q <= sub_floor(st_q, head.sl);
							else         si_q <= si_q + OW'(1);
							out_q <= OUT_FILLED_SLOW;
						end
						pord_q  <= head.ord;
						prank_q <= head_rank;
						state_q <= S_FILL_ADD;
					end
				end
				S_FILL_ADD: begin
					if (!tier_q) ft_q <= add_sat(ft_q, len_q);
					else         st_q <= add_sat(st_q, len_q);
					state_q <= S_TOUCH;
				end
				S_TOUCH: begin
					if (!pord_q) ocnt_q <= ocnt_q + OW'(1);
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q              <= 1'b1;
					rsp_q.outcome       <= out_q;
					rsp_q.evicted_count <= ev_q;
					rsp_q.fast_used     <= ft_q;
					rsp_q.slow_used     <= st_q;
					rsp_q.fast_items    <= sat_cnt(32'(fi_q));
					rsp_q.slow_items    <= sat_cnt(32'(si_q));
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hw/rtl/tlbc_checker.sv =====
// Port-level checks on the cache's command/result behaviour, bound to the top level.
module tlbc_checker import tlbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.outcome <= OUT_CLEARED))
		else $error("undefined outcome code");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.outcome == OUT_FAST_HIT || rsp.outcome == OUT_SLOW_HIT
			|| rsp.outcome == OUT_UNCACHED && rsp.evicted_count == 7'd0))
		|-> (rsp.outcome == OUT_UNCACHED || rsp.evicted_count == 7'd0))
		else $error("hit reported evictions");

endmodule

bind two_tier_lru_byte_budget_cache_top tlbc_checker u_tlbc_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the two-tier byte-budget LRU cache bookkeeping block.
module testbench;
	import tlbc_pkg::*;

	localparam int NSLOT = ENTRIES_DEF;
	localparam longint unsigned MAX40 = 64'hFF_FFFF_FFFF;
	localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [LEN_W-1:0]     cfg_wdata;

	two_tier_lru_byte_budget_cache_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Mirror of the cache bookkeeping, kept in step with each accepted transaction.
	logic [KEY_W-1:0]  m_key  [NSLOT];
	bit                m_fp   [NSLOT];
	longint unsigned   m_fl   [NSLOT];
	bit                m_sp   [NSLOT];
	longint unsigned   m_sl   [NSLOT];
	bit                m_ord  [NSLOT];
	int                m_rank [NSLOT];
	longint unsigned   m_ftot, m_stot, m_fbud, m_sbud;
	int                m_evict;

	rsp_t rsp_expected_q [$];
	int   fails, n_sent, n_checked, idle_pct;
	int   outcome_seen [8];

	function automatic bit slot_busy(int i);
		return m_fp[i] || m_sp[i] || m_ord[i];
	endfunction

	function automatic int slot_of_key(logic [KEY_W-1:0] k);
		for (int i = 0; i < NSLOT; i++)
			if (slot_busy(i) && m_key[i] == k) return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < NSLOT; i++)
			if (!slot_busy(i)) return i;
		return -1;
	endfunction

	function automatic int lru_victim();
		int v;
		v = -1;
		for (int i = 0; i < NSLOT; i++)
			if (m_ord[i] && (v < 0 || m_rank[i] > m_rank[v])) v = i;
		return v;
	endfunction

	function automatic void leave_order(int v);
		for (int i = 0; i < NSLOT; i++)
			if (m_ord[i] && m_rank[i] > m_rank[v]) m_rank[i]--;
		m_ord[v] = 0;
		m_rank[v] = 0;
		if (m_evict < 127) m_evict++;
	endfunction

	function automatic void make_recent(int s);
		for (int i = 0; i < NSLOT; i++)
			if (m_ord[i] && i != s && (!m_ord[s] || m_rank[i] < m_rank[s])) m_rank[i]++;
		m_ord[s] = 1;
		m_rank[s] = 0;
	endfunction

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
		return (a + b > MAX48) ? MAX48 : a + b;
	endfunction

	function automatic longint unsigned floor_sub(longint unsigned a, longint unsigned b);
		return (a > b) ? a - b : 0;
	endfunction

	function automatic logic [2:0] cache_read(logic [KEY_W-1:0] k, longint unsigned len);
		int s, v;
		s = slot_of_key(k);
		if (s >= 0 && m_fp[s] && m_fl[s] == len) begin
			make_recent(s);
			return OUT_FAST_HIT;
		end
		if (s >= 0 && m_sp[s] && m_sl[s] == len) begin
			make_recent(s);
			return OUT_SLOW_HIT;
		end
		if (len == 0) return OUT_UNCACHED;
		if (m_fbud >= len) begin
			// fast eviction may also drop slow copies while the slow tier is over budget
			forever begin
				if (!(m_ftot + len > m_fbud)) break;
				v = lru_victim();
				if (v < 0) break;
				if (m_fp[v]) begin
					m_ftot = floor_sub(m_ftot, m_fl[v]);
					m_fp[v] = 0;
				end
				if (m_sp[v] && m_stot > m_sbud) begin
					m_stot = floor_sub(m_stot, m_sl[v]);
					m_sp[v] = 0;
				end
				leave_order(v);
			end
			if (m_ftot + len <= m_fbud) begin
				s = slot_of_key(k);
				if (s < 0) s = free_slot();
				if (s >= 0) begin
					if (m_fp[s]) m_ftot = floor_sub(m_ftot, m_fl[s]);
					m_key[s] = k;
					m_fp[s] = 1;
					m_fl[s] = len;
					m_ftot = sat_add(m_ftot, len);
					make_recent(s);
					return OUT_FILLED_FAST;
				end
			end
		end
		if (m_sbud >= len) begin
			forever begin
				if (!(m_stot + len > m_sbud)) break;
				v = lru_victim();
				if (v < 0) break;
				if (m_sp[v]) begin
					m_stot = floor_sub(m_stot, m_sl[v]);
					m_sp[v] = 0;
				end
				leave_order(v);
			end
			if (m_stot + len <= m_sbud) begin
				s = slot_of_key(k);
				if (s < 0) s = free_slot();
				if (s >= 0) begin
					if (m_sp[s]) m_stot = floor_sub(m_stot, m_sl[s]);
					m_key[s] = k;
					m_sp[s] = 1;
					m_sl[s] = len;
					m_stot = sat_add(m_stot, len);
					make_recent(s);
					return OUT_FILLED_SLOW;
				end
			end
		end
		return OUT_UNCACHED;
	endfunction

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t o;
		longint unsigned want, stored;
		int nf, ns;
		logic [2:0] oc;
		m_evict = 0;
		nf = 0;
		ns = 0;
		if (r.req_type == REQ_CLEAR) begin
			for (int i = 0; i < NSLOT; i++) begin
				if (r.clear_level == CLR_FAST || r.clear_level == CLR_BOTH) m_fp[i] = 0;
				if (r.clear_level == CLR_SLOW || r.clear_level == CLR_BOTH) m_sp[i] = 0;
				if (m_ord[i] && m_evict < 127) m_evict++;
				m_ord[i] = 0;
				m_rank[i] = 0;
			end
			if (r.clear_level == CLR_FAST || r.clear_level == CLR_BOTH) m_ftot = 0;
			if (r.clear_level == CLR_SLOW || r.clear_level == CLR_BOTH) m_stot = 0;
			oc = OUT_CLEARED;
		end else begin
			want = r.want_bytes;
			stored = r.stored_bytes;
			if (stored == 0) oc = OUT_UNCACHED;
			else oc = cache_read({r.owner_handle, r.item_index}, (want < stored) ? want : stored);
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (m_fp[i]) nf++;
			if (m_sp[i]) ns++;
		end
		o.outcome       = oc;
		o.evicted_count = m_evict[CNT_OUT_W-1:0];
		o.fast_used     = m_ftot[TOT_W-1:0];
		o.slow_used     = m_stot[TOT_W-1:0];
		o.fast_items    = nf[CNT_OUT_W-1:0];
		o.slow_items    = ns[CNT_OUT_W-1:0];
		return o;
	endfunction

	// Result checker: every strobe must match the oldest outstanding prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (rsp_expected_q.size() == 0) begin
				$error("result with no transaction outstanding");
				fails++;
			end else begin
				e = rsp_expected_q.pop_front();
				n_checked++;
				outcome_seen[e.outcome]++;
				if (rsp.outcome !== e.outcome) begin
					$error("outcome exp %0d got %0d", e.outcome, rsp.outcome);
					fails++;
				end
				if (rsp.evicted_count !== e.evicted_count) begin
					$error("evicted_count exp %0d got %0d", e.evicted_count, rsp.evicted_count);
					fails++;
				end
				if (rsp.fast_used !== e.fast_used) begin
					$error("fast_used exp %0d got %0d", e.fast_used, rsp.fast_used);
					fails++;
				end
				if (rsp.slow_used !== e.slow_used) begin
					$error("slow_used exp %0d got %0d", e.slow_used, rsp.slow_used);
					fails++;
				end
				if (rsp.fast_items !== e.fast_items) begin
					$error("fast_items exp %0d got %0d", e.fast_items, rsp.fast_items);
					fails++;
				end
				if (rsp.slow_items !== e.slow_items) begin
					$error("slow_items exp %0d got %0d", e.slow_items, rsp.slow_items);
					fails++;
				end
			end
		end
	end

	// One transaction: optional idle gap, then hold start until busy is seen low.
	task automatic send_req(req_t r);
		rsp_t exp_rsp;
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		exp_rsp = predict_rsp(r);
		rsp_expected_q = {rsp_expected_q, exp_rsp};
		n_sent++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		while (rsp_expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Budget writes only happen with the block drained.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val[LEN_W-1:0];
		if (idx == REG_FAST_BUDGET) m_fbud = val & MAX40;
		else if (idx == REG_SLOW_BUDGET) m_sbud = val & MAX40;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_budgets(longint unsigned f, longint unsigned s);
		write_reg(REG_FAST_BUDGET, f);
		write_reg(REG_SLOW_BUDGET, s);
	endtask

	function automatic req_t rd(int h, int i, longint unsigned want, longint unsigned stored);
		req_t r;
		r = '0;
		r.req_type     = REQ_READ;
		r.owner_handle = h[7:0];
		r.item_index   = i[15:0];
		r.want_bytes   = want[LEN_W-1:0];
		r.stored_bytes = stored[LEN_W-1:0];
		r.clear_level  = 2'($urandom_range(3));
		return r;
	endfunction

	function automatic req_t clr(logic [1:0] lvl);
		req_t r;
		r = rd($urandom_range(255), $urandom_range(65535), $urandom, $urandom);
		r.req_type    = REQ_CLEAR;
		r.clear_level = lvl;
		return r;
	endfunction

	function automatic longint unsigned rand40();
		return {$urandom, $urandom} & MAX40;
	endfunction

	// Both tiers disabled after reset, then hits, fills, evictions and replacement.
	task automatic test_directed_reads();
		send_req(rd(1, 1, 100, 100));            // both budgets zero: nothing cached
		set_budgets(300, 900);
		write_reg(REG_SPARE_A, 64'h12345);       // unknown index, ignored
		write_reg(REG_SPARE_B, MAX40);
		send_req(rd(1, 2, 50, 0));               // invalid key
		send_req(rd(1, 3, 0, 70));               // zero length
		send_req(rd(1, 4, 100, 100));            // fill fast
		send_req(rd(1, 4, 500, 100));            // fast hit, want clipped to stored
		send_req(rd(1, 4, 60, 100));             // other length: replace fast copy
		send_req(rd(2, 5, 150, 150));
		send_req(rd(2, 6, 200, 200));            // fast eviction from the back
		send_req(rd(3, 7, 400, 400));            // too big for fast: slow fill
		send_req(rd(3, 7, 400, 400));            // slow hit
		send_req(rd(3, 8, 600, 600));            // slow eviction
		send_req(rd(8'hFF, 16'hFFFF, MAX40, MAX40));
		send_req(rd(0, 0, 1, MAX40));
	endtask

	task automatic test_clears();
		send_req(rd(4, 1, 100, 100));
		send_req(rd(4, 2, 500, 500));
		send_req(clr(CLR_ORDER));                // copies survive out of the order
		send_req(rd(4, 9, 290, 290));            // cannot evict entries out of the order
		send_req(rd(4, 1, 100, 100));
		send_req(clr(CLR_FAST));
		send_req(clr(CLR_SLOW));
		send_req(rd(4, 3, 80, 80));
		send_req(clr(CLR_BOTH));
		set_budgets(MAX40, MAX40);
		send_req(rd(8'hFF, 16'hFFFF, MAX40, MAX40));
		send_req(rd(8'hFE, 16'h0001, MAX40, MAX40 - 1));
		send_req(clr(CLR_BOTH));
	endtask

	// Mostly well-formed reads over a small key pool so hits and evictions are common.
	task automatic test_random_mix(int items, int pct, int keys, longint unsigned unit);
		req_t r;
		int   sel;
		longint unsigned len;
		idle_pct = pct;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				r = rd($urandom_range(255), $urandom_range(65535), rand40(), rand40());
				r.req_type = 1'($urandom_range(1));
			end else if (sel < 12) begin
				r = clr(2'($urandom_range(3)));
			end else begin
				len = unit * $urandom_range(1, 8);
				sel = $urandom_range(keys - 1);
				r = rd(sel % 4, sel / 4, ($urandom_range(9) == 0) ? $urandom_range(len) : len,
					len);
			end
			if ($urandom_range(199) == 0) wait_drained();   // hold off until all results in
			send_req(r);
		end
		wait_drained();
	endtask

	initial begin
		fails = 0;
		n_sent = 0;
		n_checked = 0;
		idle_pct = 0;
		foreach (outcome_seen[i]) outcome_seen[i] = 0;
		for (int i = 0; i < NSLOT; i++) begin
			m_key[i] = '0; m_fp[i] = 0; m_fl[i] = 0; m_sp[i] = 0;
			m_sl[i] = 0; m_ord[i] = 0; m_rank[i] = 0;
		end
		m_ftot = 0; m_stot = 0; m_fbud = 0; m_sbud = 0; m_evict = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_reads();
		test_clears();
		// settings cycle through disabled tiers, tight budgets and the extremes
		set_budgets(400, 1200);      test_random_mix(200, 0, 40, 50);
		set_budgets(0, 2000);        test_random_mix(200, 85, 40, 50);
		set_budgets(1500, 0);        test_random_mix(200, 37, 40, 50);
		set_budgets(MAX40, MAX40);   test_random_mix(200, 0, 100, 50);
		set_budgets(100, 100);       test_random_mix(200, 85, 24, 20);
		set_budgets(1000, 3000);     test_random_mix(200, 37, 60, 50);
		set_budgets(1, MAX40);       test_random_mix(200, 0, 90, 50);
		set_budgets(MAX40, 50);      test_random_mix(200, 37, 80, 7);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d transactions, checked %0d results over eight budget settings",
			n_sent, n_checked);
		$display("fast hits %0d, slow hits %0d, fast fills %0d, slow fills %0d, uncached %0d",
			outcome_seen[OUT_FAST_HIT], outcome_seen[OUT_SLOW_HIT],
			outcome_seen[OUT_FILLED_FAST], outcome_seen[OUT_FILLED_SLOW],
			outcome_seen[OUT_UNCACHED]);
		if (fails == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#(8 * 40_000_000);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tlbc_pkg.sv
hw/rtl/tlbc_cell.sv
hw/rtl/two_tier_lru_byte_budget_cache_top.sv
hw/rtl/tlbc_checker.sv
tb/sv/testbench.sv
